### hw/rtl/bps_pkg.sv
// Shared types and constants for the bitmap priority scheduler.
package bps_pkg;

    // Field widths fixed by the item format.
    localparam int PRIO_W    = 6;
    localparam int TICKS_W   = 32;
    localparam int OP_W      = 3;
    localparam int READY_W   = 32;
    localparam int MAX_PRIOS = 32;

    // Default number of prioritised threads above the idle thread.
    localparam int DEF_NUM_THREADS = 32;

    // Operation codes carried by an input item.
    typedef enum logic [OP_W-1:0] {
        OP_START  = 3'd0,
        OP_DELAY  = 3'd1,
        OP_TICK   = 3'd2,
        OP_SCHED  = 3'd3,
        OP_SWITCH = 3'd4
    } t_op;

    // Command broadcast from the controller to every cell.
    typedef enum logic [1:0] {
        CELL_NOP,
        CELL_START,
        CELL_DELAY,
        CELL_TICK
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [PRIO_W-1:0]  prio;
        logic [TICKS_W-1:0] ticks;
    } t_cell_cmd;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_HOLD
    } t_state;

endpackage

### hw/rtl/bps_cell.sv
// One thread cell: ready, delayed and registered flags, timeout, and a search token stage.
module bps_cell import bps_pkg::*; #(
    parameter int CELL_PRIO = 1
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  logic      i_tok,
    output logic      o_tok,
    output logic      o_hit,
    output logic      o_ready,
    output logic      o_delayed,
    output logic      o_reg_match
);

    logic               r_ready;
    logic               r_delayed;
    logic               r_reg;
    logic               r_tok;
    logic [TICKS_W-1:0] r_timeout;
    logic [TICKS_W-1:0] w_dec;
    logic               w_match;

    // The command addresses this cell when its priority matches.
    assign w_match     = (i_cmd.prio == PRIO_W'(CELL_PRIO));
    assign o_reg_match = w_match & r_reg;

    // Saturating count-down of the timeout.
    assign w_dec = (r_timeout != '0) ? (r_timeout - TICKS_W'(1)) : '0;

    // The search token stops at a ready cell and otherwise moves one cell down.
    assign o_hit     = r_tok & r_ready;
    assign o_tok     = r_tok & ~r_ready;
    assign o_ready   = r_ready;
    assign o_delayed = r_delayed;

    // Flags and token stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready   <= 1'b0;
            r_delayed <= 1'b0;
            r_reg     <= 1'b0;
            r_tok     <= 1'b0;
        end else begin
            r_tok <= i_tok;
            unique case (i_cmd.op)
                CELL_START: begin
                    if (w_match) begin
                        r_reg   <= 1'b1;
                        r_ready <= 1'b1;
                    end
                end
                CELL_DELAY: begin
                    if (w_match) begin
                        r_ready   <= 1'b0;
                        r_delayed <= 1'b1;
                    end
                end
                CELL_TICK: begin
                    if (r_delayed && (w_dec == '0)) begin
                        r_ready   <= 1'b1;
                        r_delayed <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Timeout register; it holds nothing meaningful until a delay writes it.
    always_ff @(posedge i_clk) begin
        if ((i_cmd.op == CELL_DELAY) && w_match) begin
            r_timeout <= i_cmd.ticks;
        end else if ((i_cmd.op == CELL_TICK) && r_delayed) begin
            r_timeout <= w_dec;
        end
    end

endmodule

### hw/rtl/bitmap_priority_scheduler.sv
// Top level of the bitmap priority scheduler: controller, cell chain and result register.
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_operation, i_priority_req, i_delay_ticks
//  out     | output    | o_out_valid / i_out_stall  | o_next_priority, o_switch_request,
//          |           |                            | o_error, o_ready_view
//
// From transfer to result, the controller first applies the operation to the cells,
// then a token walks down the cell chain one cell a cycle from the top priority until
// it meets a ready cell, and then the result register is loaded. Reset is synchronous
// and active low and clears all flags; timeouts are left as they are. A new item is
// taken once the previous one is in the result register; a stalled result holds and
// a finished item waits behind it.
module bitmap_priority_scheduler import bps_pkg::*; #(
    parameter int NUM_THREADS = DEF_NUM_THREADS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [PRIO_W-1:0]  i_priority_req,
    input  logic [TICKS_W-1:0] i_delay_ticks,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [PRIO_W-1:0]  o_next_priority,
    output logic               o_switch_request,
    output logic               o_error,
    output logic [READY_W-1:0] o_ready_view
);

    localparam int CNT_W = $clog2(NUM_THREADS + 1);

    t_state             r_state, n_state;
    logic [OP_W-1:0]    r_op;
    logic [PRIO_W-1:0]  r_prio;
    logic [TICKS_W-1:0] r_ticks;
    logic               r_err;
    logic               r_reg0;
    logic [PRIO_W-1:0]  r_cur;
    logic               r_cur_valid;
    logic [PRIO_W-1:0]  r_pend;
    logic [CNT_W-1:0]   r_scan;
    logic [PRIO_W-1:0]  r_next;
    logic               r_ovalid;
    logic [PRIO_W-1:0]  r_onext;
    logic               r_oswitch;
    logic               r_oerr;
    logic [READY_W-1:0] r_oready;

    t_cell_cmd              w_cmd;
    logic                   w_err;
    logic                   w_inject;
    logic                   w_load;
    logic                   w_any_hit;
    logic [NUM_THREADS-1:0] w_tok_in;
    logic [NUM_THREADS-1:0] w_tok_out;
    logic [NUM_THREADS-1:0] w_hit;
    logic [NUM_THREADS-1:0] w_ready;
    logic [NUM_THREADS-1:0] w_delayed;
    logic [NUM_THREADS-1:0] w_reg_match;
    logic                   w_accept;

    assign w_accept  = i_in_valid & ~o_in_stall;
    assign w_any_hit = |w_hit;
    assign w_load    = (r_state == ST_HOLD) && (!r_ovalid || !i_out_stall);

    // Cell chain; the token enters at the highest priority and walks down.
    for (genvar g = 0; g < NUM_THREADS; g++) begin : g_cell
        if (g == NUM_THREADS - 1) begin : g_top
            assign w_tok_in[g] = w_inject;
        end else begin : g_mid
            assign w_tok_in[g] = w_tok_out[g+1];
        end
        bps_cell #(
            .CELL_PRIO (g + 1)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_tok       (w_tok_in[g]),
            .o_tok       (w_tok_out[g]),
            .o_hit       (w_hit[g]),
            .o_ready     (w_ready[g]),
            .o_delayed   (w_delayed[g]),
            .o_reg_match (w_reg_match[g])
        );
    end

    // Next state, precondition checks and the command to the cells.
    always_comb begin
        n_state    = r_state;
        w_err      = 1'b0;
        w_inject   = 1'b0;
        o_in_stall = (r_state != ST_IDLE);
        w_cmd.op    = CELL_NOP;
        w_cmd.prio  = (t_op'(r_op) == OP_DELAY) ? r_cur : r_prio;
        w_cmd.ticks = r_ticks;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                w_inject = 1'b1;
                n_state  = ST_SCAN;
                unique case (r_op)
                    OP_START: begin
                        if (r_prio > PRIO_W'(NUM_THREADS)) begin
                            w_err = 1'b1;
                        end else if (r_prio == '0) begin
                            w_err = r_reg0;
                        end else begin
                            w_err = |w_reg_match;
                        end
                        if (!w_err && (r_prio != '0)) begin
                            w_cmd.op = CELL_START;
                        end
                    end
                    OP_DELAY: begin
                        w_err = !r_cur_valid || (r_cur == '0) ||
                                (r_cur > PRIO_W'(NUM_THREADS)) || (r_ticks == '0);
                        if (!w_err) begin
                            w_cmd.op = CELL_DELAY;
                        end
                    end
                    OP_TICK: begin
                        w_cmd.op = CELL_TICK;
                    end
                    OP_SCHED, OP_SWITCH: begin
                    end
                    default: begin
                        w_err = 1'b1;
                    end
                endcase
            end
            ST_SCAN: begin
                if (w_any_hit || (r_scan == CNT_W'(1))) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Captured item.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_operation;
            r_prio  <= i_priority_req;
            r_ticks <= i_delay_ticks;
        end
    end

    // Scheduler state: idle registration, current thread, pending choice and search count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg0      <= 1'b0;
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_pend      <= '0;
            r_err       <= 1'b0;
            r_scan      <= '0;
            r_next      <= '0;
        end else begin
            if (r_state == ST_EXEC) begin
                r_err  <= w_err;
                r_scan <= CNT_W'(NUM_THREADS);
                if ((r_op == OP_START) && !w_err && (r_prio == '0)) begin
                    r_reg0 <= 1'b1;
                end
                if (r_op == OP_SWITCH) begin
                    r_cur       <= r_pend;
                    r_cur_valid <= 1'b1;
                end
            end
            if (r_state == ST_SCAN) begin
                r_scan <= r_scan - CNT_W'(1);
                if (w_any_hit || (r_scan == CNT_W'(1))) begin
                    r_next <= w_any_hit ? PRIO_W'(r_scan) : '0;
                    if ((r_op == OP_SCHED) || ((r_op == OP_DELAY) && !r_err)) begin
                        r_pend <= w_any_hit ? PRIO_W'(r_scan) : '0;
                    end
                end
            end
        end
    end

    // Result register towards the output channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_onext   <= r_next;
            r_oswitch <= !r_cur_valid || (r_next != r_cur);
            r_oerr    <= r_err;
            r_oready  <= READY_W'(w_ready);
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_next_priority  = r_onext;
    assign o_switch_request = r_oswitch;
    assign o_error          = r_oerr;
    assign o_ready_view     = r_oready;

    // At most one search token is in the chain.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_out | w_hit))
        else $error("more than one search token in the cell chain");

    // A thread is never ready and delayed at once.
    a_ready_delayed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ready & w_delayed) == '0)
        else $error("thread both ready and delayed");

    // A new result appears only when a finished item is loaded.
    a_load_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_HOLD))
        else $error("result valid without a finished item");

    // Tick, schedule and switch never report an error.
    a_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HOLD) && ((r_op == OP_TICK) || (r_op == OP_SCHED) ||
        (r_op == OP_SWITCH)) |-> !r_err)
        else $error("error flagged on an operation that cannot fail");

    // No search token is left in the chain while the controller is idle.
    a_tok_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (w_tok_out == '0))
        else $error("search token left in the chain while idle");

endmodule
